// ----- rtl/core/xksc_pkg.sv -----
// Shared types and constants for the xorshift keystream cipher.
// No dependencies; used by every module in rtl/core.
package xksc_pkg;

   localparam int DATA_W            = 8;
   localparam int CFG_DATA_W        = 64;
   localparam int CFG_ADDR_W        = 6;
   localparam int KEY_WORDS         = 4;
   localparam int KEY_BYTES         = 32;
   localparam int KEY_IDX_W         = 5;
   localparam int KEY_LEN_W         = 6;
   localparam int DEF_MAX_KEY_BYTES = 32;

   localparam logic [63:0] FNV_BASIS     = 64'hCBF2_9CE4_8422_2325;
   // FNV prime is 2^40 + 0x1B3
   localparam int          FNV_PRIME_SHL = 40;
   localparam logic [8:0]  FNV_PRIME_LOW = 9'h1B3;
   // only the low half of the multiplier reaches the folded byte
   localparam logic [31:0] KS_MULT_LOW   = 32'h4F6C_DD1D;

   localparam int XS_SHIFT_A = 12;
   localparam int XS_SHIFT_B = 25;
   localparam int XS_SHIFT_C = 27;

   typedef enum logic [2:0] {
      REG_KEY_WORD_0 = 3'd0,
      REG_KEY_WORD_1 = 3'd1,
      REG_KEY_WORD_2 = 3'd2,
      REG_KEY_WORD_3 = 3'd3,
      REG_KEY_LENGTH = 3'd4
   } cfg_reg_type;

   typedef logic [KEY_WORDS-1:0][63:0] key_words_type;

   typedef struct packed {
      logic hash_init;
      logic hash_step;
      logic hash_done;
      logic sel_hash;
      logic accept;
      logic s2_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hash_last;
   } dp_status_type;

endpackage

// ----- rtl/core/xksc_csr.sv -----
// Configuration register file: four key words and the key length.
// Depends on xksc_pkg.
module xksc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [xksc_pkg::CFG_ADDR_W-1:0]     csr_paddr,
   input  logic [xksc_pkg::CFG_DATA_W-1:0]     csr_pwdata,
   output logic [xksc_pkg::CFG_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output xksc_pkg::key_words_type             key_words,
   output logic [xksc_pkg::KEY_LEN_W-1:0]      key_length
);

   localparam int CFG_ADDR_HI = xksc_pkg::CFG_ADDR_W - 1;

   xksc_pkg::key_words_type                key_words_ff;
   logic [xksc_pkg::KEY_LEN_W-1:0]         key_length_ff;
   xksc_pkg::cfg_reg_type                  reg_sel;
   logic                                   wr_en;

   assign reg_sel    = xksc_pkg::cfg_reg_type'(csr_paddr[CFG_ADDR_HI:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign key_words  = key_words_ff;
   assign key_length = key_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_words_ff  <= '0;
         key_length_ff <= xksc_pkg::KEY_LEN_W'(1);
      end else if (wr_en) begin
         unique case (reg_sel)
            xksc_pkg::REG_KEY_WORD_0: key_words_ff[0] <= csr_pwdata;
            xksc_pkg::REG_KEY_WORD_1: key_words_ff[1] <= csr_pwdata;
            xksc_pkg::REG_KEY_WORD_2: key_words_ff[2] <= csr_pwdata;
            xksc_pkg::REG_KEY_WORD_3: key_words_ff[3] <= csr_pwdata;
            xksc_pkg::REG_KEY_LENGTH: key_length_ff <= csr_pwdata[xksc_pkg::KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         xksc_pkg::REG_KEY_WORD_0: csr_prdata = key_words_ff[0];
         xksc_pkg::REG_KEY_WORD_1: csr_prdata = key_words_ff[1];
         xksc_pkg::REG_KEY_WORD_2: csr_prdata = key_words_ff[2];
         xksc_pkg::REG_KEY_WORD_3: csr_prdata = key_words_ff[3];
         xksc_pkg::REG_KEY_LENGTH: csr_prdata = xksc_pkg::CFG_DATA_W'(key_length_ff);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

// ----- rtl/core/xksc_ctrl.sv -----
// Controller: message-start hashing sequence and the two-stage item pipeline.
// Depends on xksc_pkg; drives xksc_dpath through ctrl_cmd_type.
module xksc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tlast,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  xksc_pkg::dp_status_type  status,
   output xksc_pkg::ctrl_cmd_type   cmd
);

   typedef enum logic {
      ST_RUN,
      ST_HASH
   } state_type;

   state_type state_ff, state_in;
   logic      at_start_ff, at_start_in;
   logic      s1_valid_ff, s1_valid_in;
   logic      out_valid_ff, out_valid_in;
   logic      advance;
   logic      accept;

   assign advance    = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = (state_ff == ST_RUN) & ~at_start_ff & (~s1_valid_ff | advance);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      at_start_in  = at_start_ff;
      cmd          = '0;
      cmd.accept   = accept;
      cmd.s2_load  = advance;
      s1_valid_in  = accept | (s1_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & ~rsp_tready);
      unique case (state_ff)
         ST_RUN: begin
            if (at_start_ff && req_tvalid) begin
               cmd.hash_init = 1'b1;
               state_in      = ST_HASH;
            end
            if (accept && req_tlast) begin
               at_start_in = 1'b1;
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            cmd.sel_hash  = 1'b1;
            if (status.hash_last) begin
               cmd.hash_done = 1'b1;
               at_start_in   = 1'b0;
               state_in      = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         at_start_ff  <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         at_start_ff  <= at_start_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- rtl/core/xksc_dpath.sv -----
// Datapath: FNV-1a seed hash, xorshift64* generator, key position and output stage.
// Depends on xksc_pkg; commanded by xksc_ctrl.
module xksc_dpath #(
   parameter int MAX_KEY_BYTES = xksc_pkg::DEF_MAX_KEY_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  xksc_pkg::ctrl_cmd_type           cmd,
   output xksc_pkg::dp_status_type          status,
   input  xksc_pkg::key_words_type          key_words,
   input  logic [xksc_pkg::KEY_LEN_W-1:0]   key_length,
   input  logic [xksc_pkg::DATA_W-1:0]      in_data,
   input  logic                             in_last,
   output logic [xksc_pkg::DATA_W-1:0]      out_byte,
   output logic                             out_last
);

   localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int IDX_W = (CNT_W > xksc_pkg::KEY_IDX_W + 1) ? CNT_W : xksc_pkg::KEY_IDX_W + 1;

   logic [63:0]                  gen_ff;
   logic [CNT_W-1:0]             hash_idx_ff;
   logic [CNT_W-1:0]             pos_ff;
   logic [xksc_pkg::DATA_W-1:0]  s1_mix_ff;
   logic [31:0]                  s1_x_ff;
   logic                         s1_last_ff;
   logic [xksc_pkg::DATA_W-1:0]  out_byte_ff;
   logic                         out_last_ff;

   logic [CNT_W-1:0]             len;
   logic [CNT_W-1:0]             pos_eff;
   logic [CNT_W-1:0]             pos_inc;
   logic [CNT_W-1:0]             pos_in;
   logic [IDX_W-1:0]             idx_ext;
   logic [7:0]                   key_bytes [xksc_pkg::KEY_BYTES];
   logic [7:0]                   kb;
   logic [63:0]                  fnv_y;
   logic [63:0]                  fnv_in;
   logic [63:0]                  xs_a, xs_b, xs_c;
   logic [31:0]                  ks;
   logic [7:0]                   fold;

   always_comb begin
      if (key_length == '0) begin
         len = CNT_W'(1);
      end else if (int'(key_length) > MAX_KEY_BYTES) begin
         len = CNT_W'(MAX_KEY_BYTES);
      end else begin
         len = CNT_W'(key_length);
      end
   end

   assign status.hash_last = (hash_idx_ff == len - CNT_W'(1));

   // key position wraps if the length shrank mid-message
   assign pos_eff = (pos_ff >= len) ? '0 : pos_ff;
   assign pos_inc = pos_eff + CNT_W'(1);
   assign pos_in  = (pos_inc >= len) ? '0 : pos_inc;

   always_comb begin
      for (int i = 0; i < xksc_pkg::KEY_BYTES; i++) begin
         key_bytes[i] = key_words[i >> 3][(i & 7) * 8 +: 8];
      end
   end

   assign idx_ext = IDX_W'(cmd.sel_hash ? hash_idx_ff : pos_eff);
   assign kb      = (idx_ext >= IDX_W'(xksc_pkg::KEY_BYTES)) ? 8'h00
                    : key_bytes[idx_ext[xksc_pkg::KEY_IDX_W-1:0]];

   assign fnv_y  = gen_ff ^ {56'h0, kb};
   assign fnv_in = (fnv_y << xksc_pkg::FNV_PRIME_SHL) + fnv_y * {55'h0, xksc_pkg::FNV_PRIME_LOW};

   assign xs_a = gen_ff ^ (gen_ff >> xksc_pkg::XS_SHIFT_A);
   assign xs_b = xs_a ^ (xs_a << xksc_pkg::XS_SHIFT_B);
   assign xs_c = xs_b ^ (xs_b >> xksc_pkg::XS_SHIFT_C);

   assign ks   = s1_x_ff * xksc_pkg::KS_MULT_LOW;
   assign fold = ks[7:0] ^ ks[15:8] ^ ks[23:16] ^ ks[31:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.hash_done) begin
         pos_ff <= '0;
      end else if (cmd.accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hash_init) begin
         gen_ff      <= xksc_pkg::FNV_BASIS;
         hash_idx_ff <= '0;
      end else if (cmd.hash_step) begin
         gen_ff      <= fnv_in;
         hash_idx_ff <= hash_idx_ff + CNT_W'(1);
      end else if (cmd.accept) begin
         gen_ff <= xs_c;
      end
      if (cmd.accept) begin
         s1_mix_ff  <= in_data ^ kb;
         s1_x_ff    <= xs_c[31:0];
         s1_last_ff <= in_last;
      end
      if (cmd.s2_load) begin
         out_byte_ff <= s1_mix_ff ^ fold;
         out_last_ff <= s1_last_ff;
      end
   end

   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;

endmodule

// ----- rtl/core/xorshift_keystream_cipher.sv -----
// Byte-stream XOR cipher: each byte is XORed with a folded xorshift64* output byte and
// a key byte; tlast ends a message. Steady throughput is one byte per clock unless
// the output stalls or a reseed runs; each byte passes the stage-1 and output registers.
// At the first byte of every message the generator is reseeded by an FNV-1a hash of the
// key, one key byte per cycle through the hash unit (length clamped to 1..MAX_KEY_BYTES).
// Depends on xksc_pkg, xksc_csr, xksc_ctrl and xksc_dpath.
module xorshift_keystream_cipher #(
   parameter int MAX_KEY_BYTES = xksc_pkg::DEF_MAX_KEY_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [xksc_pkg::DATA_W-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,   // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [xksc_pkg::DATA_W-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                             rsp_tlast,   // out_last
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [xksc_pkg::CFG_ADDR_W-1:0]  csr_paddr,
   input  logic [xksc_pkg::CFG_DATA_W-1:0]  csr_pwdata,
   output logic [xksc_pkg::CFG_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   xksc_pkg::key_words_type            key_words;
   logic [xksc_pkg::KEY_LEN_W-1:0]     key_length;
   xksc_pkg::ctrl_cmd_type             cmd;
   xksc_pkg::dp_status_type            status;

   xksc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_words   (key_words),
      .key_length  (key_length)
   );

   xksc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   xksc_dpath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .key_words  (key_words),
      .key_length (key_length),
      .in_data    (req_tdata),
      .in_last    (req_tlast),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule
